FILE: rtl/escaped_frame_receiver_top_macros.svh
// Assertion macros shared by the receiver RTL.
`ifndef ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_TOP_MACROS_SVH

// Check that holds in the same cycle as its antecedent.
`define EFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that holds in the cycle after its antecedent.
`define EFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/efr_pkg.sv
package efr_pkg;

	localparam int IDX_W = 9;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] FLAG_START = 8'h7b;
	localparam logic [BYTE_W-1:0] FLAG_ESC   = 8'h7c;
	localparam logic [BYTE_W-1:0] FLAG_END   = 8'h7d;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RECV = 2'd1,
		MODE_DONE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_APPEND   = 3'd1,
		ST_MERGE    = 3'd2,
		ST_END      = 3'd3,
		ST_OVERFLOW = 3'd4,
		ST_HELD     = 3'd5
	} status_t;

	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_index;
		logic [BYTE_W-1:0] wr_value;
		logic              frame_done;
		logic [IDX_W-1:0]  frame_len;
		status_t           status;
	} efr_res_t;

endpackage

FILE: rtl/efr_if.sv
interface efr_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface efr_out_if;
	logic       valid;
	logic       ready;
	logic       wr_en;
	logic [8:0] wr_index;
	logic [7:0] wr_value;
	logic       frame_done;
	logic [8:0] frame_len;
	logic [2:0] status;

	modport source (output valid, output wr_en, output wr_index, output wr_value,
		output frame_done, output frame_len, output status, input ready);
	modport sink (input valid, input wr_en, input wr_index, input wr_value,
		input frame_done, input frame_len, input status, output ready);
endinterface

FILE: rtl/efr_ctrl.sv
module efr_ctrl #(
	parameter int BUF_MAX = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              action,
	input  logic [efr_pkg::BYTE_W-1:0]        rx_byte,
	output efr_pkg::efr_res_t                 res
);
	import efr_pkg::*;

	// The count can reach one above the bound before bytes are dropped.
	localparam int CW = $clog2(BUF_MAX + 2);
	localparam logic [CW-1:0] BUF_LIM = CW'(BUF_MAX);

	mode_t             mode_q, mode_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [BYTE_W-1:0] raw_q, raw_d;
	logic [BYTE_W-1:0] stored_q, stored_d;
	logic              ovf;
	logic              merge;
	logic [CW-1:0]     cnt_dec;

	assign ovf     = cnt_q > BUF_LIM;
	assign merge   = (raw_q == FLAG_ESC) && (cnt_q != '0);
	assign cnt_dec = cnt_q - CW'(1);

	// Next mode.
	always_comb begin
		mode_d = mode_q;
		if (action) begin
			mode_d = MODE_IDLE;
		end else begin
			unique case (mode_q)
				MODE_RECV: begin
					if (!ovf && rx_byte == FLAG_END) begin
						mode_d = MODE_DONE;
					end
				end
				MODE_DONE: mode_d = MODE_DONE;
				default: begin
					mode_d = (rx_byte == FLAG_START) ? MODE_RECV : MODE_IDLE;
				end
			endcase
		end
	end

	// Buffer write, counters and the result word.
	always_comb begin
		cnt_d    = cnt_q;
		raw_d    = raw_q;
		stored_d = stored_q;
		res      = '0;
		res.status = ST_IDLE;
		if (action) begin
			cnt_d    = '0;
			raw_d    = '0;
			stored_d = '0;
		end else begin
			unique case (mode_q)
				MODE_RECV: begin
					priority if (ovf) begin
						res.status = ST_OVERFLOW;
					end else if (rx_byte == FLAG_END) begin
						res.wr_en      = 1'b1;
						res.wr_index   = IDX_W'(cnt_q);
						res.wr_value   = rx_byte;
						res.frame_done = 1'b1;
						res.status     = ST_END;
						cnt_d          = cnt_q + CW'(1);
						stored_d       = rx_byte;
					end else if (rx_byte == FLAG_START) begin
						res.wr_en    = 1'b1;
						res.wr_value = rx_byte;
						res.status   = ST_APPEND;
						cnt_d        = CW'(1);
						raw_d        = '0;
						stored_d     = rx_byte;
					end else if (merge) begin
						res.wr_en    = 1'b1;
						res.wr_index = IDX_W'(cnt_dec);
						res.wr_value = stored_q ^ rx_byte;
						res.status   = ST_MERGE;
						stored_d     = stored_q ^ rx_byte;
						raw_d        = rx_byte;
					end else begin
						res.wr_en    = 1'b1;
						res.wr_index = IDX_W'(cnt_q);
						res.wr_value = rx_byte;
						res.status   = ST_APPEND;
						cnt_d        = cnt_q + CW'(1);
						stored_d     = rx_byte;
						raw_d        = rx_byte;
					end
				end
				MODE_DONE: res.status = ST_HELD;
				default: begin
					if (rx_byte == FLAG_START) begin
						res.wr_en    = 1'b1;
						res.wr_value = rx_byte;
						res.status   = ST_APPEND;
						cnt_d        = CW'(1);
						raw_d        = '0;
						stored_d     = rx_byte;
					end
				end
			endcase
		end
		res.frame_len = IDX_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			cnt_q    <= '0;
			raw_q    <= '0;
			stored_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			cnt_q    <= cnt_d;
			raw_q    <= raw_d;
			stored_q <= stored_d;
		end
	end

endmodule

FILE: rtl/efr_outreg.sv
module efr_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  efr_pkg::efr_res_t res_d,
	input  logic              out_ready,
	output logic              out_valid,
	output efr_pkg::efr_res_t res_q
);
	import efr_pkg::*;

	logic valid_q;

	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

FILE: rtl/escaped_frame_receiver_top.sv
// A result word is registered and appears in the cycle after its input word is taken.
// Throughput: one word per cycle; input ready follows the output register,
// which is free when empty or being drained in the same cycle.
// Reset (arst_n low, asynchronous) returns to idle with an empty frame and
// an empty output register.
`include "escaped_frame_receiver_top_macros.svh"

module escaped_frame_receiver_top #(
	parameter int BUF_MAX = 256
) (
	input logic       clk,
	input logic       arst_n,
	efr_in_if.sink    frame_in,
	efr_out_if.source frame_out
);
	import efr_pkg::*;

	logic     accept;
	efr_res_t res_d;
	efr_res_t res_q;
	logic     out_valid;

	assign frame_in.ready = !out_valid || frame_out.ready;
	assign accept = frame_in.valid && frame_in.ready;

	efr_ctrl #(
		.BUF_MAX(BUF_MAX)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (frame_in.action),
		.rx_byte (frame_in.rx_byte),
		.res     (res_d)
	);

	efr_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res_d),
		.out_ready (frame_out.ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign frame_out.valid      = out_valid;
	assign frame_out.wr_en      = res_q.wr_en;
	assign frame_out.wr_index   = res_q.wr_index;
	assign frame_out.wr_value   = res_q.wr_value;
	assign frame_out.frame_done = res_q.frame_done;
	assign frame_out.frame_len  = res_q.frame_len;
	assign frame_out.status     = res_q.status;

	`EFR_ASSERT_NEXT(a_accept_gives_word, clk, arst_n, accept, out_valid, "accepted word lost")
	`EFR_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid && !frame_out.ready, !accept, "result overwritten")
	`EFR_ASSERT_NOW(a_done_writes, clk, arst_n, res_d.frame_done, res_d.wr_en && res_d.status == ST_END, "frame end without write")
	`EFR_ASSERT_NOW(a_merge_last, clk, arst_n, res_d.status == ST_MERGE, res_d.wr_en && IDX_W'(res_d.wr_index + 9'd1) == res_d.frame_len, "merge off the last entry")

endmodule
